### design/proximity_contact_table_assert.svh
// assertion macros for the proximity contact table
`ifndef PROXIMITY_CONTACT_TABLE_ASSERT_SVH
`define PROXIMITY_CONTACT_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PTC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PTC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define PTC_ASSERT(lbl, clk, rst_n, prop, msg)
`define PTC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

### design/ptc_pkg.sv
package ptc_pkg;

    localparam int DEF_NEAR_DEPTH  = 64;
    localparam int DEF_CLOSE_DEPTH = 256;
    localparam int DEF_TIME_BITS   = 32;

    localparam int ADDR_BITS = 48;
    localparam int REG_BITS  = 31;

    localparam logic [REG_BITS-1:0] NEAR_WINDOW_RST = 31'd12000;
    localparam logic [REG_BITS-1:0] CLOSE_MIN_RST   = 31'd3000;
    localparam logic [REG_BITS-1:0] CLOSE_RET_RST   = 31'd12096000;

    localparam logic [1:0] REG_NEAR_WINDOW = 2'd0;
    localparam logic [1:0] REG_CLOSE_MIN   = 2'd1;
    localparam logic [1:0] REG_CLOSE_RET   = 2'd2;

    typedef enum logic [2:0] {
        OUT_NEW_NEAR   = 3'd0,
        OUT_TOO_SOON   = 3'd1,
        OUT_PROMOTED   = 3'd2,
        OUT_ALREADY    = 3'd3,
        OUT_NEAR_FULL  = 3'd4,
        OUT_CLOSE_FULL = 3'd5,
        OUT_READ       = 3'd6
    } outcome_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_WRITE,
        ST_READ
    } state_t;

endpackage

### design/ptc_cell.sv
module ptc_cell import ptc_pkg::*; #(
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift,
    input  logic                 d_valid,
    input  logic [ADDR_BITS-1:0] d_addr,
    input  logic [TIME_BITS-1:0] d_time,
    output logic                 q_valid,
    output logic [ADDR_BITS-1:0] q_addr,
    output logic [TIME_BITS-1:0] q_time
);

    logic                 valid_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [TIME_BITS-1:0] time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            addr_reg <= d_addr;
            time_reg <= d_time;
        end
    end

    assign q_valid = valid_reg;
    assign q_addr  = addr_reg;
    assign q_time  = time_reg;

endmodule

### design/ptc_ring.sv
module ptc_ring import ptc_pkg::*; #(
    parameter int DEPTH     = DEF_NEAR_DEPTH,
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift,
    input  logic                 tail_valid,
    input  logic [ADDR_BITS-1:0] tail_addr,
    input  logic [TIME_BITS-1:0] tail_time,
    output logic                 head_valid,
    output logic [ADDR_BITS-1:0] head_addr,
    output logic [TIME_BITS-1:0] head_time
);

    logic                 v [DEPTH];
    logic [ADDR_BITS-1:0] a [DEPTH];
    logic [TIME_BITS-1:0] t [DEPTH];

    // each cell takes its upper neighbour; the top cell takes the tail inputs, which the parent drives
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                 dv;
        logic [ADDR_BITS-1:0] da;
        logic [TIME_BITS-1:0] dt;
        if (i == DEPTH - 1)
        begin : g_tail
            assign dv = tail_valid;
            assign da = tail_addr;
            assign dt = tail_time;
        end
        else
        begin : g_mid
            assign dv = v[i+1];
            assign da = a[i+1];
            assign dt = t[i+1];
        end
        ptc_cell #(.TIME_BITS(TIME_BITS)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (shift),
            .d_valid (dv),
            .d_addr  (da),
            .d_time  (dt),
            .q_valid (v[i]),
            .q_addr  (a[i]),
            .q_time  (t[i])
        );
    end

    assign head_valid = v[0];
    assign head_addr  = a[0];
    assign head_time  = t[0];

endmodule

### design/proximity_contact_table.sv
// Proximity contact table.
// Command channel: a word (kind, device_address, now_ms, read_index) is taken on
// a clock edge with start high and busy low. busy stays high while it is worked.
// One result word appears on the result ports with done high for one cycle; the
// receiver cannot hold it off, and a new word may be started in that same cycle.
// Both tables are rings of cells that rotate one entry a cycle, while shifted,
// past a head cell. A sighting rotates both rings through one full turn each
// (expiry and lookup), then decides and, when it stores, rotates the target
// ring once more to write its slot. A read rotates the close ring once; the
// done strobe is registered after the last step.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the
// user must make them only while idle, as the block itself does not enforce it.
// Reset clears all valid bits and fill marks at once and loads the register
// defaults; no clearing pass is needed.
module proximity_contact_table import ptc_pkg::*; #(
    parameter int NEAR_DEPTH  = DEF_NEAR_DEPTH,
    parameter int CLOSE_DEPTH = DEF_CLOSE_DEPTH,
    parameter int TIME_BITS   = DEF_TIME_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [REG_BITS-1:0]  cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic                 kind,
    input  logic [ADDR_BITS-1:0] device_address,
    input  logic [31:0]          now_ms,
    input  logic [7:0]           read_index,
    output logic                 done,
    output logic [2:0]           outcome,
    output logic [7:0]           slot,
    output logic [6:0]           near_fill_out,
    output logic [8:0]           close_fill_out,
    output logic                 read_valid,
    output logic [ADDR_BITS-1:0] read_address,
    output logic [31:0]          read_time
);

`include "proximity_contact_table_assert.svh"

    localparam int MAXD = (NEAR_DEPTH > CLOSE_DEPTH) ? NEAR_DEPTH : CLOSE_DEPTH;
    localparam int CW   = $clog2(MAXD + 1);
    localparam int NFW  = $clog2(NEAR_DEPTH + 1);
    localparam int CFW  = $clog2(CLOSE_DEPTH + 1);
    localparam int IXW  = ((CW > 8) ? CW : 8) + 1;
    localparam int AW   = (TIME_BITS > REG_BITS) ? TIME_BITS : REG_BITS;

    localparam logic [CW-1:0] NEAR_LAST  = CW'(NEAR_DEPTH - 1);
    localparam logic [CW-1:0] CLOSE_LAST = CW'(CLOSE_DEPTH - 1);
    localparam logic [CW-1:0] MAX_LAST   = CW'(MAXD - 1);
    localparam logic [CW-1:0] NEAR_D     = CW'(NEAR_DEPTH);
    localparam logic [CW-1:0] CLOSE_D    = CW'(CLOSE_DEPTH);
    localparam logic [NFW-1:0] NEAR_FULL  = NFW'(NEAR_DEPTH);
    localparam logic [CFW-1:0] CLOSE_FULL = CFW'(CLOSE_DEPTH);

    state_t state_reg, state_next;

    logic [REG_BITS-1:0] near_win_reg, close_min_reg, close_ret_reg;

    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [NFW-1:0] near_fill_reg, near_fill_next;
    logic [CFW-1:0] close_fill_reg, close_fill_next;

    logic                 kind_reg, kind_next;
    logic [ADDR_BITS-1:0] key_reg, key_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [7:0]           ridx_reg, ridx_next;

    logic                 nhit_reg, nhit_next;
    logic [CW-1:0]        nhit_idx_reg, nhit_idx_next;
    logic [TIME_BITS-1:0] nhit_time_reg, nhit_time_next;
    logic                 nfree_reg, nfree_next;
    logic [CW-1:0]        nfree_idx_reg, nfree_idx_next;
    logic                 chit_reg, chit_next;
    logic [CW-1:0]        chit_idx_reg, chit_idx_next;
    logic                 cfree_reg, cfree_next;
    logic [CW-1:0]        cfree_idx_reg, cfree_idx_next;

    logic          tgt_close_reg, tgt_close_next;
    logic [CW-1:0] tgt_idx_reg, tgt_idx_next;

    logic                 done_reg, done_next;
    outcome_t             outcome_reg, outcome_next;
    logic [7:0]           slot_reg, slot_next;
    logic                 rvalid_reg, rvalid_next;
    logic [ADDR_BITS-1:0] raddr_reg, raddr_next;
    logic [TIME_BITS-1:0] rtime_reg, rtime_next;

    logic                 n_shift, n_tv, n_hv;
    logic [ADDR_BITS-1:0] n_ta, n_ha;
    logic [TIME_BITS-1:0] n_tt, n_ht;
    logic                 c_shift, c_tv, c_hv;
    logic [ADDR_BITS-1:0] c_ta, c_ha;
    logic [TIME_BITS-1:0] c_tt, c_ht;

    logic [AW-1:0] n_age, c_age, hit_age;
    logic          n_in, c_in, n_keep, c_keep, at_tgt, at_ridx;

    ptc_ring #(.DEPTH(NEAR_DEPTH), .TIME_BITS(TIME_BITS)) u_near (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift      (n_shift),
        .tail_valid (n_tv),
        .tail_addr  (n_ta),
        .tail_time  (n_tt),
        .head_valid (n_hv),
        .head_addr  (n_ha),
        .head_time  (n_ht)
    );

    ptc_ring #(.DEPTH(CLOSE_DEPTH), .TIME_BITS(TIME_BITS)) u_close (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift      (c_shift),
        .tail_valid (c_tv),
        .tail_addr  (c_ta),
        .tail_time  (c_tt),
        .head_valid (c_hv),
        .head_addr  (c_ha),
        .head_time  (c_ht)
    );

    // head entry: age, inside fill mark, still live after expiry
    always_comb
    begin
        n_age   = AW'(TIME_BITS'(now_reg - n_ht));
        c_age   = AW'(TIME_BITS'(now_reg - c_ht));
        hit_age = AW'(TIME_BITS'(now_reg - nhit_time_reg));
        n_in    = IXW'(cnt_reg) < IXW'(near_fill_reg);
        c_in    = IXW'(cnt_reg) < IXW'(close_fill_reg);
        n_keep  = n_hv && !(n_in && (n_age > AW'(near_win_reg)));
        c_keep  = c_hv && !(c_in && (c_age > AW'(close_ret_reg)));
        at_tgt  = cnt_reg == tgt_idx_reg;
        at_ridx = IXW'(cnt_reg) == IXW'(ridx_reg);
    end

    always_comb
    begin
        n_shift = 1'b0;
        c_shift = 1'b0;
        n_tv    = n_hv;
        n_ta    = n_ha;
        n_tt    = n_ht;
        c_tv    = c_hv;
        c_ta    = c_ha;
        c_tt    = c_ht;
        unique case (state_reg)
            ST_SCAN:
            begin
                n_shift = cnt_reg < NEAR_D;
                c_shift = cnt_reg < CLOSE_D;
                n_tv    = n_keep;
                c_tv    = c_keep;
            end
            ST_WRITE:
            begin
                n_shift = !tgt_close_reg;
                c_shift = tgt_close_reg;
                if (at_tgt)
                begin
                    n_tv = 1'b1;
                    n_ta = key_reg;
                    n_tt = now_reg;
                    c_tv = 1'b1;
                    c_ta = key_reg;
                    c_tt = now_reg;
                end
            end
            ST_READ:
            begin
                c_shift = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = kind ? ST_READ : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == MAX_LAST)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (outcome_next == OUT_NEW_NEAR || outcome_next == OUT_PROMOTED)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WRITE:
            begin
                if (cnt_reg == (tgt_close_reg ? CLOSE_LAST : NEAR_LAST))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (cnt_reg == CLOSE_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next        = cnt_reg + CW'(1);
        near_fill_next  = near_fill_reg;
        close_fill_next = close_fill_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        now_next        = now_reg;
        ridx_next       = ridx_reg;
        nhit_next       = nhit_reg;
        nhit_idx_next   = nhit_idx_reg;
        nhit_time_next  = nhit_time_reg;
        nfree_next      = nfree_reg;
        nfree_idx_next  = nfree_idx_reg;
        chit_next       = chit_reg;
        chit_idx_next   = chit_idx_reg;
        cfree_next      = cfree_reg;
        cfree_idx_next  = cfree_idx_reg;
        tgt_close_next  = tgt_close_reg;
        tgt_idx_next    = tgt_idx_reg;
        done_next       = 1'b0;
        outcome_next    = outcome_reg;
        slot_next       = slot_reg;
        rvalid_next     = rvalid_reg;
        raddr_next      = raddr_reg;
        rtime_next      = rtime_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next   = '0;
                kind_next  = kind;
                key_next   = device_address;
                now_next   = TIME_BITS'(now_ms);
                ridx_next  = read_index;
                nhit_next  = 1'b0;
                nfree_next = 1'b0;
                chit_next  = 1'b0;
                cfree_next = 1'b0;
                rvalid_next = 1'b0;
                raddr_next  = '0;
                rtime_next  = '0;
            end
            ST_SCAN:
            begin
                if (cnt_reg < NEAR_D && n_in)
                begin
                    if (n_keep && n_ha == key_reg)
                    begin
                        nhit_next      = 1'b1;
                        nhit_idx_next  = cnt_reg;
                        nhit_time_next = n_ht;
                    end
                    if (!n_keep)
                    begin
                        nfree_next     = 1'b1;
                        nfree_idx_next = cnt_reg;
                    end
                end
                if (cnt_reg < CLOSE_D && c_in)
                begin
                    if (c_keep && c_ha == key_reg)
                    begin
                        chit_next     = 1'b1;
                        chit_idx_next = cnt_reg;
                    end
                    if (!c_keep)
                    begin
                        cfree_next     = 1'b1;
                        cfree_idx_next = cnt_reg;
                    end
                end
            end
            ST_DECIDE:
            begin
                cnt_next  = '0;
                slot_next = '0;
                if (nhit_reg)
                begin
                    tgt_close_next = 1'b1;
                    if (chit_reg)
                    begin
                        outcome_next = OUT_ALREADY;
                        slot_next    = 8'(chit_idx_reg);
                    end
                    else if (hit_age < AW'(close_min_reg))
                    begin
                        outcome_next = OUT_TOO_SOON;
                        slot_next    = 8'(nhit_idx_reg);
                    end
                    else if (cfree_reg)
                    begin
                        outcome_next = OUT_PROMOTED;
                        tgt_idx_next = cfree_idx_reg;
                        slot_next    = 8'(cfree_idx_reg);
                    end
                    else if (close_fill_reg != CLOSE_FULL)
                    begin
                        outcome_next    = OUT_PROMOTED;
                        tgt_idx_next    = CW'(close_fill_reg);
                        slot_next       = 8'(close_fill_reg);
                        close_fill_next = close_fill_reg + CFW'(1);
                    end
                    else
                    begin
                        outcome_next = OUT_CLOSE_FULL;
                    end
                end
                else
                begin
                    tgt_close_next = 1'b0;
                    if (nfree_reg)
                    begin
                        outcome_next = OUT_NEW_NEAR;
                        tgt_idx_next = nfree_idx_reg;
                        slot_next    = 8'(nfree_idx_reg);
                    end
                    else if (near_fill_reg != NEAR_FULL)
                    begin
                        outcome_next   = OUT_NEW_NEAR;
                        tgt_idx_next   = CW'(near_fill_reg);
                        slot_next      = 8'(near_fill_reg);
                        near_fill_next = near_fill_reg + NFW'(1);
                    end
                    else
                    begin
                        outcome_next = OUT_NEAR_FULL;
                    end
                end
                if (!(outcome_next == OUT_NEW_NEAR || outcome_next == OUT_PROMOTED))
                begin
                    done_next = 1'b1;
                end
            end
            ST_WRITE:
            begin
                if (cnt_reg == (tgt_close_reg ? CLOSE_LAST : NEAR_LAST))
                begin
                    done_next = 1'b1;
                end
            end
            ST_READ:
            begin
                outcome_next = OUT_READ;
                slot_next    = ridx_reg;
                if (at_ridx && c_in && c_hv && c_age <= AW'(close_ret_reg))
                begin
                    rvalid_next = 1'b1;
                    raddr_next  = c_ha;
                    rtime_next  = c_ht;
                end
                if (cnt_reg == CLOSE_LAST)
                begin
                    done_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            near_fill_reg  <= '0;
            close_fill_reg <= '0;
            done_reg       <= 1'b0;
            near_win_reg   <= NEAR_WINDOW_RST;
            close_min_reg  <= CLOSE_MIN_RST;
            close_ret_reg  <= CLOSE_RET_RST;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            near_fill_reg  <= near_fill_next;
            close_fill_reg <= close_fill_next;
            done_reg       <= done_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_NEAR_WINDOW: near_win_reg  <= cfg_data;
                    REG_CLOSE_MIN:   close_min_reg <= cfg_data;
                    REG_CLOSE_RET:   close_ret_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        key_reg       <= key_next;
        now_reg       <= now_next;
        ridx_reg      <= ridx_next;
        nhit_reg      <= nhit_next;
        nhit_idx_reg  <= nhit_idx_next;
        nhit_time_reg <= nhit_time_next;
        nfree_reg     <= nfree_next;
        nfree_idx_reg <= nfree_idx_next;
        chit_reg      <= chit_next;
        chit_idx_reg  <= chit_idx_next;
        cfree_reg     <= cfree_next;
        cfree_idx_reg <= cfree_idx_next;
        tgt_close_reg <= tgt_close_next;
        tgt_idx_reg   <= tgt_idx_next;
        outcome_reg   <= outcome_next;
        slot_reg      <= slot_next;
        rvalid_reg    <= rvalid_next;
        raddr_reg     <= raddr_next;
        rtime_reg     <= rtime_next;
    end

    assign busy           = state_reg != ST_IDLE;
    assign done           = done_reg;
    assign outcome        = outcome_reg;
    assign slot           = slot_reg;
    assign near_fill_out  = 7'(near_fill_reg);
    assign close_fill_out = 9'(close_fill_reg);
    assign read_valid     = rvalid_reg;
    assign read_address   = raddr_reg;
    assign read_time      = 32'(rtime_reg);

    // kind is sampled while idle and held for the word in hand
    `PTC_ASSERT(a_done_idle, clk, rst_n, !done || !busy, "result strobed while busy")
    `PTC_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "word taken but not busy")
    `PTC_ASSERT(a_near_fill, clk, rst_n, !(near_fill_reg > NEAR_FULL), "near fill past depth")
    `PTC_ASSERT(a_read_kind, clk, rst_n, !(state_reg == ST_READ) || kind_reg, "read without read word")

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ptc_pkg::*;

    localparam int NDEPTH = 64;
    localparam int CDEPTH = 256;
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int POOL = 320;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [7:0]  slot;
        logic [6:0]  near_fill;
        logic [8:0]  close_fill;
        logic        rvalid;
        logic [47:0] raddr;
        logic [31:0] rtime;
    } contact_word_t;

    class contact_scoreboard;
        logic [30:0] near_window, close_min, close_ret;
        bit          nvalid [NDEPTH];
        logic [47:0] naddr [NDEPTH];
        logic [31:0] ntime [NDEPTH];
        int          nfill;
        bit          cvalid [CDEPTH];
        logic [47:0] caddr [CDEPTH];
        logic [31:0] ctime [CDEPTH];
        int          cfill;
        contact_word_t pending [$];
        int          errors;

        function new();
            near_window = NEAR_WINDOW_RST;
            close_min   = CLOSE_MIN_RST;
            close_ret   = CLOSE_RET_RST;
            nfill = 0;
            cfill = 0;
            errors = 0;
            foreach (nvalid[k]) nvalid[k] = 0;
            foreach (cvalid[k]) cvalid[k] = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [30:0] val);
            if (idx == REG_NEAR_WINDOW) near_window = val;
            else if (idx == REG_CLOSE_MIN) close_min = val;
            else if (idx == REG_CLOSE_RET) close_ret = val;
        endfunction

        function void note(logic knd, logic [47:0] addr, logic [31:0] now, logic [7:0] ridx);
            contact_word_t r;
            int npos, cpos;
            r = '0;
            if (knd)
            begin
                r.outcome = OUT_READ;
                r.slot = ridx;
                if (ridx < cfill && cvalid[ridx] && 32'(now - ctime[ridx]) <= {1'b0, close_ret})
                begin
                    r.rvalid = 1;
                    r.raddr = caddr[ridx];
                    r.rtime = ctime[ridx];
                end
            end
            else
            begin
                for (int k = 0; k < nfill; k++)
                    if (nvalid[k] && 32'(now - ntime[k]) > {1'b0, near_window})
                        nvalid[k] = 0;
                for (int k = 0; k < cfill; k++)
                    if (cvalid[k] && 32'(now - ctime[k]) > {1'b0, close_ret})
                        cvalid[k] = 0;
                npos = -1;
                for (int k = 0; k < nfill; k++)
                    if (nvalid[k] && naddr[k] == addr) npos = k;
                if (npos >= 0)
                begin
                    cpos = -1;
                    for (int k = 0; k < cfill; k++)
                        if (cvalid[k] && caddr[k] == addr) cpos = k;
                    if (cpos >= 0)
                    begin
                        r.outcome = OUT_ALREADY;
                        r.slot = 8'(cpos);
                    end
                    else if (32'(now - ntime[npos]) < {1'b0, close_min})
                    begin
                        r.outcome = OUT_TOO_SOON;
                        r.slot = 8'(npos);
                    end
                    else
                    begin
                        for (int k = 0; k < cfill; k++)
                            if (!cvalid[k]) cpos = k;
                        if (cpos < 0 && cfill < CDEPTH) cpos = cfill;
                        if (cpos < 0) r.outcome = OUT_CLOSE_FULL;
                        else
                        begin
                            cvalid[cpos] = 1;
                            caddr[cpos] = addr;
                            ctime[cpos] = now;
                            if (cpos == cfill) cfill++;
                            r.outcome = OUT_PROMOTED;
                            r.slot = 8'(cpos);
                        end
                    end
                end
                else
                begin
                    for (int k = 0; k < nfill; k++)
                        if (!nvalid[k]) npos = k;
                    if (npos < 0 && nfill < NDEPTH) npos = nfill;
                    if (npos < 0) r.outcome = OUT_NEAR_FULL;
                    else
                    begin
                        nvalid[npos] = 1;
                        naddr[npos] = addr;
                        ntime[npos] = now;
                        if (npos == nfill) nfill++;
                        r.outcome = OUT_NEW_NEAR;
                        r.slot = 8'(npos);
                    end
                end
            end
            r.near_fill = 7'(nfill);
            r.close_fill = 9'(cfill);
            pending.push_back(r);
        endfunction

        function void check(contact_word_t got);
            contact_word_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result word");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.outcome !== e.outcome)
            begin
                $error("outcome exp %0d got %0d", e.outcome, got.outcome); errors++;
            end
            if (got.slot !== e.slot)
            begin
                $error("slot exp %0d got %0d", e.slot, got.slot); errors++;
            end
            if (got.near_fill !== e.near_fill)
            begin
                $error("near_fill_out exp %0d got %0d", e.near_fill, got.near_fill); errors++;
            end
            if (got.close_fill !== e.close_fill)
            begin
                $error("close_fill_out exp %0d got %0d", e.close_fill, got.close_fill); errors++;
            end
            if (got.rvalid !== e.rvalid)
            begin
                $error("read_valid exp %0d got %0d", e.rvalid, got.rvalid); errors++;
            end
            if (got.raddr !== e.raddr)
            begin
                $error("read_address exp %h got %h", e.raddr, got.raddr); errors++;
            end
            if (got.rtime !== e.rtime)
            begin
                $error("read_time exp %h got %h", e.rtime, got.rtime); errors++;
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [REG_BITS-1:0] cfg_data;
    logic start, busy, kind, done, read_valid;
    logic [ADDR_BITS-1:0] device_address, read_address;
    logic [31:0] now_ms, read_time;
    logic [7:0] read_index, slot;
    logic [2:0] outcome;
    logic [6:0] near_fill_out;
    logic [8:0] close_fill_out;

    contact_scoreboard sb;
    logic [47:0] addr_pool [POOL];
    logic [31:0] clock_ms;
    int idle_pct;
    int base;

    proximity_contact_table uut (.*);

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check({outcome, slot, near_fill_out, close_fill_out,
                      read_valid, read_address, read_time});
    end

    task automatic send_word(logic k, logic [47:0] a, logic [31:0] t, logic [7:0] ri);
        kind <= k;
        device_address <= a;
        now_ms <= t;
        read_index <= ri;
        start <= 1;
        forever
        begin
            @(posedge clk);
            if (!busy) break;
        end
        sb.note(k, a, t, ri);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic set_all(logic [30:0] w, logic [30:0] m, logic [30:0] r);
        drain();
        write_reg(REG_NEAR_WINDOW, w);
        write_reg(REG_CLOSE_MIN, m);
        write_reg(REG_CLOSE_RET, r);
        write_reg(REG_SPARE, 31'($urandom()));
        cfg_we <= 0;
    endtask

    task automatic run_phase(int n, int pool_span, int max_step, int read_pct);
        logic [47:0] a;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 2) clock_ms += $urandom();
            else clock_ms += $urandom_range(0, max_step);
            if ($urandom_range(0, 3) == 0) base = (base + 1) % pool_span;
            if ($urandom_range(0, 99) < 8) a = 48'({$urandom(), $urandom()});
            else a = addr_pool[(base + $urandom_range(0, 3)) % pool_span];
            if ($urandom_range(0, 99) < read_pct)
                send_word(1, 48'({$urandom(), $urandom()}), clock_ms, 8'($urandom()));
            else
                send_word(0, a, clock_ms, 8'($urandom()));
        end
    endtask

    initial
    begin
        #100_000_000;
        $display("proximity_contact_table: mismatch");
        $finish;
    end

    initial
    begin
        sb = new();
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        start = 0;
        kind = 0;
        device_address = '0;
        now_ms = '0;
        read_index = '0;
        idle_pct = 0;
        base = 0;
        foreach (addr_pool[k]) addr_pool[k] = 48'({$urandom(), $urandom()});
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: defaults, address extremes, promotion path, reads, time wrap
        clock_ms = 32'hFFFF_F000;
        send_word(0, 48'h0, clock_ms, 8'h00);
        send_word(0, 48'hFFFF_FFFF_FFFF, clock_ms, 8'hFF);
        send_word(0, 48'h0, clock_ms + 100, 8'h00);
        clock_ms += 3000;
        send_word(0, 48'h0, clock_ms, 8'h00);
        send_word(0, 48'h0, clock_ms + 1, 8'h00);
        send_word(0, 48'hFFFF_FFFF_FFFF, clock_ms + 5, 8'h00);
        send_word(1, 48'hFFFF_FFFF_FFFF, clock_ms + 6, 8'h00);
        send_word(1, 48'h0, clock_ms + 6, 8'h01);
        send_word(1, 48'h0, clock_ms + 6, 8'h02);
        send_word(1, 48'h0, clock_ms + 6, 8'hFF);
        send_word(0, 48'h5555_5555_5555, clock_ms + 7, 8'h00);
        send_word(0, 48'hAAAA_AAAA_AAAA, clock_ms + 8, 8'h00);
        clock_ms += 13000;
        send_word(0, 48'hAAAA_AAAA_AAAA, clock_ms, 8'h00);
        send_word(1, 48'h0, clock_ms, 8'h00);
        clock_ms += 32'd12_100_000;
        send_word(1, 48'h0, clock_ms, 8'h00);
        send_word(0, 48'h1234_5678_9ABC, clock_ms, 8'h00);
        send_word(1, 48'h0, clock_ms, 8'h00);

        idle_pct = 0;
        run_phase(150, 40, 2000, 10);
        set_all(31'd100, 31'd20, 31'd3000);
        idle_pct = 59;
        run_phase(300, 80, 15, 10);
        set_all(31'd50, 31'd0, 31'h7FFF_FFFF);
        idle_pct = 0;
        run_phase(550, POOL, 6, 5);
        set_all(31'd1, 31'd1, 31'd1);
        idle_pct = 25;
        run_phase(200, 70, 2, 15);
        set_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        idle_pct = 59;
        run_phase(200, 90, 50, 10);
        set_all(31'd400, 31'd30, 31'd2000);
        idle_pct = 25;
        run_phase(300, 120, 20, 15);

        start <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("proximity_contact_table: match");
        else
            $display("proximity_contact_table: mismatch");
        $finish;
    end
endmodule

### sim.f
+incdir+design
design/ptc_pkg.sv
design/ptc_cell.sv
design/ptc_ring.sv
design/proximity_contact_table.sv
test/tb_top.sv
